[rtl/gtf_pkg.sv]
// Package for the grouped team FIFO: field widths, request and status codes,
// controller states and the command and status bundles between the controller and
// the datapath. No dependencies.
`default_nettype none

package gtf_pkg;

    // Widths of the word fields on the request and response channels.
    localparam int REQ_W  = 2;
    localparam int ELEM_W = 10;
    localparam int TEAM_W = 6;
    localparam int STAT_W = 2;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ASSIGN  = 2'd0,
        REQ_ENQUEUE = 2'd1,
        REQ_DEQUEUE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req_type;

    // Response status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status_code;

    // Controller states.
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ASSIGN,
        S_CLEAR,
        S_ENQ_LOOK,
        S_ENQ_COMMIT,
        S_DEQ_PICK,
        S_DEQ_READ,
        S_DEQ_COMMIT,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic latch;
        logic do_assign;
        logic do_clear;
        logic enq_lookup;
        logic enq_full;
        logic enq_commit;
        logic deq_pick;
        logic deq_empty;
        logic deq_read;
        logic deq_commit;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_done;
        logic store_full;
        logic order_empty;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/gtf_if.sv]
// Channel interfaces for the grouped team FIFO: request and response, each with
// valid, ready and its payload. Depends on gtf_pkg.
`default_nettype none

interface gtf_req_if;
    logic                       valid;
    logic                       ready;
    logic [gtf_pkg::REQ_W-1:0]  req_type;
    logic [gtf_pkg::ELEM_W-1:0] element;
    logic [gtf_pkg::TEAM_W-1:0] team_id;

    modport source (output valid, req_type, element, team_id, input ready);
    modport sink   (input valid, req_type, element, team_id, output ready);
endinterface

interface gtf_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       out_valid;
    logic [gtf_pkg::ELEM_W-1:0] out_element;
    logic [gtf_pkg::STAT_W-1:0] status;

    modport source (output valid, out_valid, out_element, status, input ready);
    modport sink   (input valid, out_valid, out_element, status, output ready);
endinterface

`default_nettype wire

[rtl/grouped_team_fifo.sv]
// Request steps: assign and clear through S_ASSIGN or S_CLEAR; enqueue through look-up
// and commit; dequeue through pick, read and commit; full enqueue and empty dequeue
// go straight to the result. One request at a time; the next is taken in the cycle
// after the response is loaded into the output register.
// After reset the membership table is cleared, one entry a cycle, with request
// ready low. Depends on gtf_pkg, gtf_if, gtf_ctrl, gtf_dpath.
`default_nettype none

module grouped_team_fifo #(
    parameter int ELEMENTS = 1024,
    parameter int TEAMS    = 64,
    parameter int CAPACITY = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtf_req_if.sink   i_req,
    gtf_rsp_if.source o_rsp
);

    gtf_pkg::t_dp_cmd  w_cmd;
    gtf_pkg::t_dp_stat w_stat;

    // Request sequencing.
    gtf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Storage and pointer logic.
    gtf_dpath #(
        .ELEMENTS (ELEMENTS),
        .TEAMS    (TEAMS),
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_element (i_req.element),
        .i_req_team_id (i_req.team_id),
        .i_out_ready   (o_rsp.ready),
        .o_out_wvalid  (o_rsp.valid),
        .o_out_valid   (o_rsp.out_valid),
        .o_out_element (o_rsp.out_element),
        .o_status      (o_rsp.status)
    );

endmodule

`default_nettype wire

[rtl/gtf_ctrl.sv]
// Controller of the grouped team FIFO: the state machine that sequences each
// request through the datapath. Depends on gtf_pkg.
`default_nettype none

module gtf_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  logic [gtf_pkg::REQ_W-1:0] i_req_type,
    output logic                      o_req_ready,
    input  gtf_pkg::t_dp_stat         i_stat,
    output gtf_pkg::t_dp_cmd          o_cmd
);

    gtf_pkg::t_state    r_state;
    gtf_pkg::t_state    n_state;
    gtf_pkg::t_req_type w_req;

    assign w_req = gtf_pkg::t_req_type'(i_req_type);

    // State register; reset starts the membership clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gtf_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            gtf_pkg::S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_stat.init_done) begin
                    n_state = gtf_pkg::S_IDLE;
                end
            end
            gtf_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (w_req)
                        gtf_pkg::REQ_ASSIGN:  n_state = gtf_pkg::S_ASSIGN;
                        gtf_pkg::REQ_ENQUEUE: n_state = gtf_pkg::S_ENQ_LOOK;
                        gtf_pkg::REQ_DEQUEUE: n_state = gtf_pkg::S_DEQ_PICK;
                        gtf_pkg::REQ_CLEAR:   n_state = gtf_pkg::S_CLEAR;
                        default:              n_state = gtf_pkg::S_IDLE;
                    endcase
                end
            end
            gtf_pkg::S_ASSIGN: begin
                o_cmd.do_assign = 1'b1;
                n_state         = gtf_pkg::S_DONE;
            end
            gtf_pkg::S_CLEAR: begin
                o_cmd.do_clear = 1'b1;
                n_state        = gtf_pkg::S_DONE;
            end
            gtf_pkg::S_ENQ_LOOK: begin
                if (i_stat.store_full) begin
                    o_cmd.enq_full = 1'b1;
                    n_state        = gtf_pkg::S_DONE;
                end else begin
                    o_cmd.enq_lookup = 1'b1;
                    n_state          = gtf_pkg::S_ENQ_COMMIT;
                end
            end
            gtf_pkg::S_ENQ_COMMIT: begin
                o_cmd.enq_commit = 1'b1;
                n_state          = gtf_pkg::S_DONE;
            end
            gtf_pkg::S_DEQ_PICK: begin
                if (i_stat.order_empty) begin
                    o_cmd.deq_empty = 1'b1;
                    n_state         = gtf_pkg::S_DONE;
                end else begin
                    o_cmd.deq_pick = 1'b1;
                    n_state        = gtf_pkg::S_DEQ_READ;
                end
            end
            gtf_pkg::S_DEQ_READ: begin
                o_cmd.deq_read = 1'b1;
                n_state        = gtf_pkg::S_DEQ_COMMIT;
            end
            gtf_pkg::S_DEQ_COMMIT: begin
                o_cmd.deq_commit = 1'b1;
                n_state          = gtf_pkg::S_DONE;
            end
            gtf_pkg::S_DONE: begin
                // Hand the result to the output register once it has room.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = gtf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gtf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/gtf_dpath.sv]
// Datapath of the grouped team FIFO: membership table, team order FIFO, list
// pointers, slot store with its free stack, and the output register.
// Depends on gtf_pkg.
`default_nettype none

module gtf_dpath #(
    parameter int ELEMENTS = 1024,
    parameter int TEAMS    = 64,
    parameter int CAPACITY = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gtf_pkg::t_dp_cmd           i_cmd,
    output gtf_pkg::t_dp_stat          o_stat,
    input  logic [gtf_pkg::ELEM_W-1:0] i_req_element,
    input  logic [gtf_pkg::TEAM_W-1:0] i_req_team_id,
    input  logic                       i_out_ready,
    output logic                       o_out_wvalid,
    output logic                       o_out_valid,
    output logic [gtf_pkg::ELEM_W-1:0] o_out_element,
    output logic [gtf_pkg::STAT_W-1:0] o_status
);

    localparam int EW  = $clog2(ELEMENTS);
    localparam int TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
    localparam int SW  = $clog2(CAPACITY);
    localparam int OCW = $clog2(TEAMS + 1);
    localparam int UCW = $clog2(CAPACITY + 1);
    localparam logic [31:0] ELEM_LIM = 32'(ELEMENTS);
    localparam logic [31:0] TEAM_LIM = 32'(TEAMS);

    // Memories with registered read data.
    logic [TW-1:0]              r_member_mem [ELEMENTS];
    logic [TW-1:0]              r_member_q;
    logic [TW-1:0]              r_order_mem [TEAMS];
    logic [TW-1:0]              r_order_q;
    logic [SW-1:0]              r_lhead_mem [TEAMS];
    logic [SW-1:0]              r_lhead_q;
    logic [SW-1:0]              r_ltail_mem [TEAMS];
    logic [SW-1:0]              r_ltail_q;
    logic [gtf_pkg::ELEM_W-1:0] r_sval_mem [CAPACITY];
    logic [gtf_pkg::ELEM_W-1:0] r_sval_q;
    logic [SW-1:0]              r_snext_mem [CAPACITY];
    logic [SW-1:0]              r_snext_q;

    // Control registers.
    logic [EW-1:0]    r_init;
    logic [TEAMS-1:0] r_active;
    logic [TW-1:0]    r_order_head;
    logic [TW-1:0]    r_order_tail;
    logic [OCW-1:0]   r_order_cnt;
    logic [SW-1:0]    r_free_head;
    logic [UCW-1:0]   r_stack_cnt;
    logic [UCW-1:0]   r_fresh;
    logic [UCW-1:0]   r_used;
    logic             r_out_valid;

    // Request and work registers.
    logic [gtf_pkg::ELEM_W-1:0] r_elem;
    logic [gtf_pkg::TEAM_W-1:0] r_team_id;
    logic [TW-1:0]              r_team;
    logic [SW-1:0]              r_slot;
    logic                       r_last;
    logic                       r_res_valid;
    logic [gtf_pkg::ELEM_W-1:0] r_res_elem;
    gtf_pkg::t_status_code      r_res_status;
    logic                       r_out_flag;
    logic [gtf_pkg::ELEM_W-1:0] r_out_elem;
    gtf_pkg::t_status_code      r_out_status;

    // Combinational nets.
    logic [31:0]                w_req_elem32;
    logic [31:0]                w_elem32;
    logic [31:0]                w_team32;
    logic                       w_elem_in;
    logic                       w_team_in;
    logic [EW-1:0]              w_member_ra;
    logic [TW-1:0]              w_enq_team;
    logic [TW-1:0]              w_pick_team;
    logic [SW-1:0]              w_alloc_slot;
    logic [SW-1:0]              w_snext_ra;
    logic                       w_team_act;
    logic                       w_member_we;
    logic [EW-1:0]              w_member_wa;
    logic [TW-1:0]              w_member_wd;
    logic                       w_order_we;
    logic                       w_lhead_we;
    logic [SW-1:0]              w_lhead_wd;
    logic                       w_snext_we;
    logic [SW-1:0]              w_snext_wa;
    logic [SW-1:0]              w_snext_wd;
    logic [TW-1:0]              w_head_inc;
    logic [TW-1:0]              w_tail_inc;

    // Range checks and addresses.
    assign w_req_elem32 = 32'(i_req_element);
    assign w_elem32     = 32'(r_elem);
    assign w_team32     = 32'(r_team_id);
    assign w_elem_in    = w_elem32 < ELEM_LIM;
    assign w_team_in    = w_team32 < TEAM_LIM;
    assign w_member_ra  = w_req_elem32[EW-1:0];

    // An element outside the table belongs to team 0.
    assign w_enq_team   = w_elem_in ? r_member_q : '0;
    assign w_pick_team  = i_cmd.deq_pick ? r_order_q : w_enq_team;
    assign w_team_act   = r_active[r_team];

    // Slot allocation: the stack of freed slots first, then never-used slots in order.
    assign w_alloc_slot = (r_stack_cnt != '0) ? r_free_head : r_fresh[SW-1:0];
    assign w_snext_ra   = i_cmd.deq_read ? r_lhead_q : r_free_head;

    // Circular pointer increments for the team order FIFO.
    assign w_head_inc = (r_order_head == TW'(TEAMS - 1)) ? '0 : r_order_head + 1'b1;
    assign w_tail_inc = (r_order_tail == TW'(TEAMS - 1)) ? '0 : r_order_tail + 1'b1;

    // Write port controls.
    assign w_member_we = i_cmd.init_step | (i_cmd.do_assign & w_elem_in & w_team_in);
    assign w_member_wa = i_cmd.init_step ? r_init : w_elem32[EW-1:0];
    assign w_member_wd = i_cmd.init_step ? '0 : w_team32[TW-1:0];
    assign w_order_we  = i_cmd.enq_commit & ~w_team_act;
    assign w_lhead_we  = (i_cmd.enq_commit & ~w_team_act) | (i_cmd.deq_commit & ~r_last);
    assign w_lhead_wd  = i_cmd.enq_commit ? w_alloc_slot : r_snext_q;
    assign w_snext_we  = (i_cmd.enq_commit & w_team_act) | i_cmd.deq_commit;
    assign w_snext_wa  = i_cmd.enq_commit ? r_ltail_q : r_slot;
    assign w_snext_wd  = i_cmd.enq_commit ? w_alloc_slot : r_free_head;

    // Membership table.
    always_ff @(posedge i_clk) begin
        if (w_member_we) begin
            r_member_mem[w_member_wa] <= w_member_wd;
        end
        r_member_q <= r_member_mem[w_member_ra];
    end

    // Team order FIFO storage.
    always_ff @(posedge i_clk) begin
        if (w_order_we) begin
            r_order_mem[r_order_tail] <= r_team;
        end
        r_order_q <= r_order_mem[r_order_head];
    end

    // Head and tail slot of each team list.
    always_ff @(posedge i_clk) begin
        if (w_lhead_we) begin
            r_lhead_mem[r_team] <= w_lhead_wd;
        end
        if (i_cmd.enq_commit) begin
            r_ltail_mem[r_team] <= w_alloc_slot;
        end
        r_lhead_q <= r_lhead_mem[w_pick_team];
        r_ltail_q <= r_ltail_mem[w_pick_team];
    end

    // Slot store: element values and links.
    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_commit) begin
            r_sval_mem[w_alloc_slot] <= r_elem;
        end
        if (w_snext_we) begin
            r_snext_mem[w_snext_wa] <= w_snext_wd;
        end
        r_sval_q  <= r_sval_mem[r_lhead_q];
        r_snext_q <= r_snext_mem[w_snext_ra];
    end

    // Queue bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init       <= '0;
            r_active     <= '0;
            r_order_head <= '0;
            r_order_tail <= '0;
            r_order_cnt  <= '0;
            r_free_head  <= '0;
            r_stack_cnt  <= '0;
            r_fresh      <= '0;
            r_used       <= '0;
        end else begin
            if (i_cmd.init_step) begin
                r_init <= r_init + 1'b1;
            end
            if (i_cmd.do_clear) begin
                r_active     <= '0;
                r_order_head <= '0;
                r_order_tail <= '0;
                r_order_cnt  <= '0;
                r_free_head  <= '0;
                r_stack_cnt  <= '0;
                r_fresh      <= '0;
                r_used       <= '0;
            end
            if (i_cmd.enq_commit) begin
                if (!w_team_act) begin
                    r_active[r_team] <= 1'b1;
                    r_order_tail     <= w_tail_inc;
                    r_order_cnt      <= r_order_cnt + 1'b1;
                end
                if (r_stack_cnt != '0) begin
                    r_free_head <= r_snext_q;
                    r_stack_cnt <= r_stack_cnt - 1'b1;
                end else begin
                    r_fresh <= r_fresh + 1'b1;
                end
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.deq_commit) begin
                if (r_last) begin
                    r_active[r_team] <= 1'b0;
                    r_order_head     <= w_head_inc;
                    r_order_cnt      <= r_order_cnt - 1'b1;
                end
                r_free_head <= r_slot;
                r_stack_cnt <= r_stack_cnt + 1'b1;
                r_used      <= r_used - 1'b1;
            end
        end
    end

    // Request capture, working team and slot, and the pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_elem    <= i_req_element;
            r_team_id <= i_req_team_id;
        end
        if (i_cmd.enq_lookup | i_cmd.deq_pick) begin
            r_team <= w_pick_team;
        end
        if (i_cmd.deq_read) begin
            r_slot <= r_lhead_q;
            r_last <= (r_lhead_q == r_ltail_q);
        end
        if (i_cmd.do_assign | i_cmd.do_clear | i_cmd.enq_commit) begin
            r_res_valid  <= 1'b0;
            r_res_elem   <= '0;
            r_res_status <= gtf_pkg::ST_OK;
        end
        if (i_cmd.enq_full) begin
            r_res_valid  <= 1'b0;
            r_res_elem   <= '0;
            r_res_status <= gtf_pkg::ST_FULL;
        end
        if (i_cmd.deq_empty) begin
            r_res_valid  <= 1'b0;
            r_res_elem   <= '0;
            r_res_status <= gtf_pkg::ST_EMPTY;
        end
        if (i_cmd.deq_commit) begin
            r_res_valid  <= 1'b1;
            r_res_elem   <= r_sval_q;
            r_res_status <= gtf_pkg::ST_OK;
        end
    end

    // Output register: holds a word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_flag   <= r_res_valid;
            r_out_elem   <= r_res_elem;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_wvalid  = r_out_valid;
    assign o_out_valid   = r_out_flag;
    assign o_out_element = r_out_elem;
    assign o_status      = r_out_status;

    // Status to the controller.
    assign o_stat.init_done   = (r_init == EW'(ELEMENTS - 1));
    assign o_stat.store_full  = (r_used == UCW'(CAPACITY));
    assign o_stat.order_empty = (r_order_cnt == '0);
    assign o_stat.out_free    = ~r_out_valid | i_out_ready;

endmodule

`default_nettype wire

[rtl/gtf_checker.sv]
// Port-level checks for the grouped team FIFO and the bind that attaches them
// to the top level. Depends on gtf_pkg and grouped_team_fifo.
`default_nettype none

module gtf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic                       i_out_valid,
    input logic [gtf_pkg::ELEM_W-1:0] i_out_element,
    input logic [gtf_pkg::STAT_W-1:0] i_status
);

    // A request is worked on alone: ready drops right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in progress");

    // A returned element always comes with an ok status.
    a_elem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_out_valid) |-> (i_status == gtf_pkg::ST_OK))
        else $error("returned element with error status");

    // Without a returned element the element field reads zero.
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_out_valid) |-> (i_out_element == '0))
        else $error("nonzero element without a returned element");

    // A stalled response word holds.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_out_valid) && $stable(i_out_element)
             && $stable(i_status)))
        else $error("stalled response changed");

endmodule

bind grouped_team_fifo gtf_checker u_gtf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_out_valid   (o_rsp.out_valid),
    .i_out_element (o_rsp.out_element),
    .i_status      (o_rsp.status)
);

`default_nettype wire
